// ===== rtl/tmr_pkg.sv =====
package tmr_pkg;

  localparam int unsigned MAP_TILES = 128;
  localparam int unsigned GROUPS    = 2048;
  localparam int unsigned MEGATILES = 8192;
  localparam int unsigned MINITILES = 32768;

  localparam int unsigned MAP_DEPTH    = MAP_TILES * MAP_TILES;
  localparam int unsigned GROUP_DEPTH  = GROUPS * 16;
  localparam int unsigned MEGA_DEPTH   = MEGATILES * 16;
  localparam int unsigned COLOUR_DEPTH = MINITILES * 64;
  localparam int unsigned PAL_DEPTH    = 256;

  localparam int unsigned MAP_AW    = $clog2(MAP_DEPTH);
  localparam int unsigned GROUP_AW  = $clog2(GROUP_DEPTH);
  localparam int unsigned MEGA_AW   = $clog2(MEGA_DEPTH);
  localparam int unsigned COLOUR_AW = $clog2(COLOUR_DEPTH);
  localparam int unsigned PAL_AW    = $clog2(PAL_DEPTH);

  typedef enum logic [2:0] {
    FUNC_MAP     = 3'd0,
    FUNC_GROUP   = 3'd1,
    FUNC_MEGA    = 3'd2,
    FUNC_COLOUR  = 3'd3,
    FUNC_FLAG    = 3'd4,
    FUNC_PALETTE = 3'd5,
    FUNC_RENDER  = 3'd6
  } func_e;

  // one item as it travels down the lookup pipeline
  typedef struct packed {
    logic        valid;
    logic [2:0]  func;
    logic [20:0] addr;
    logic [23:0] val;
    logic [11:0] px;
    logic [11:0] py;
  } pipe_t;

  function automatic logic is_walkable(input logic [15:0] flag);
    return flag inside {16'd1, 16'd3, 16'd17, 16'd19};
  endfunction

endpackage

// ===== rtl/tmr_in_if.sv =====
interface tmr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [20:0] table_address;
  logic [23:0] write_value;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;

  modport source (
    output valid, func, table_address, write_value, pixel_x, pixel_y,
    input  ready
  );
  modport sink (
    input  valid, func, table_address, write_value, pixel_x, pixel_y,
    output ready
  );
endinterface

// ===== rtl/tmr_out_if.sv =====
interface tmr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       walkable;

  modport source (
    output valid, red, green, blue, walkable,
    input  ready
  );
  modport sink (
    input  valid, red, green, blue, walkable,
    output ready
  );
endinterface

// ===== rtl/tmr_tile_lookup.sv =====
module tmr_tile_lookup (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  tmr_pkg::pipe_t      item_i,
  output tmr_pkg::pipe_t      item_o,
  output logic [15:0]         mega_o
);

  logic [15:0] map_mem [tmr_pkg::MAP_DEPTH];
  logic [15:0] grp_mem [tmr_pkg::GROUP_DEPTH];

  logic [15:0]     map_rd_q;
  logic [15:0]     grp_rd_q;
  tmr_pkg::pipe_t  s1_q, s2_q;
  logic            map_ok_q, grp_ok_q;

  logic [6:0]                      tx, ty;
  logic                            tile_in;
  logic [31:0]                     tile_idx;
  logic                            map_we, map_re;
  logic [tmr_pkg::MAP_AW-1:0]      map_idx;

  logic [15:0]                     word;
  logic [15:0]                     grp_sel;
  logic                            grp_in;
  logic                            grp_we, grp_re;
  logic [tmr_pkg::GROUP_AW-1:0]    grp_idx;

  // stage 0: map word read, or map write
  always_comb begin
    tx       = item_i.px[11:5];
    ty       = item_i.py[11:5];
    tile_in  = (32'(tx) < tmr_pkg::MAP_TILES) && (32'(ty) < tmr_pkg::MAP_TILES);
    tile_idx = 32'(ty) * tmr_pkg::MAP_TILES + 32'(tx);
    map_we   = item_i.valid && (item_i.func == tmr_pkg::FUNC_MAP) &&
               (32'(item_i.addr) < tmr_pkg::MAP_DEPTH);
    map_re   = item_i.valid && (item_i.func == tmr_pkg::FUNC_RENDER) && tile_in;
    map_idx  = map_we ? item_i.addr[tmr_pkg::MAP_AW-1:0] : tile_idx[tmr_pkg::MAP_AW-1:0];
  end

  // stage 1: group entry read, or group write
  always_comb begin
    word    = map_ok_q ? map_rd_q : 16'd0;
    grp_sel = word;  // {group, index} is group*16+index
    grp_in  = 32'(word[15:4]) < tmr_pkg::GROUPS;
    grp_we  = s1_q.valid && (s1_q.func == tmr_pkg::FUNC_GROUP) &&
              (32'(s1_q.addr) < tmr_pkg::GROUP_DEPTH);
    grp_re  = s1_q.valid && (s1_q.func == tmr_pkg::FUNC_RENDER) && grp_in;
    grp_idx = grp_we ? s1_q.addr[tmr_pkg::GROUP_AW-1:0] : grp_sel[tmr_pkg::GROUP_AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q     <= '0;
      s2_q     <= '0;
      map_ok_q <= 1'b0;
      grp_ok_q <= 1'b0;
    end else if (en_i) begin
      s1_q     <= item_i;
      s2_q     <= s1_q;
      map_ok_q <= map_re;
      grp_ok_q <= grp_re;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (map_we) map_mem[map_idx] <= item_i.val[15:0];
      if (map_re) map_rd_q <= map_mem[map_idx];
      if (grp_we) grp_mem[grp_idx] <= s1_q.val[15:0];
      if (grp_re) grp_rd_q <= grp_mem[grp_idx];
    end
  end

  assign item_o = s2_q;
  assign mega_o = grp_ok_q ? grp_rd_q : 16'd0;

endmodule

// ===== rtl/tmr_cell_lookup.sv =====
module tmr_cell_lookup (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  tmr_pkg::pipe_t      item_i,
  input  logic [15:0]         mega_i,
  output tmr_pkg::pipe_t      item_o,
  output logic [15:0]         ment_o,
  output logic                walk_o
);

  logic [15:0] mega_mem [tmr_pkg::MEGA_DEPTH];
  logic [15:0] flag_mem [tmr_pkg::MEGA_DEPTH];

  logic [15:0]     ment_rd_q, flag_rd_q;
  tmr_pkg::pipe_t  s3_q;
  logic            ok_q;

  logic [3:0]                    quad;
  logic [19:0]                   sel;
  logic                          mega_in, is_render;
  logic                          mega_we, flag_we, rd_en;
  logic [tmr_pkg::MEGA_AW-1:0]   mega_idx, flag_idx;

  always_comb begin
    quad      = {item_i.py[4:3], item_i.px[4:3]};
    sel       = {mega_i, quad};
    mega_in   = 32'(mega_i) < tmr_pkg::MEGATILES;
    is_render = item_i.valid && (item_i.func == tmr_pkg::FUNC_RENDER);
    rd_en     = is_render && mega_in;
    mega_we   = item_i.valid && (item_i.func == tmr_pkg::FUNC_MEGA) &&
                (32'(item_i.addr) < tmr_pkg::MEGA_DEPTH);
    flag_we   = item_i.valid && (item_i.func == tmr_pkg::FUNC_FLAG) &&
                (32'(item_i.addr) < tmr_pkg::MEGA_DEPTH);
    mega_idx  = mega_we ? item_i.addr[tmr_pkg::MEGA_AW-1:0] : sel[tmr_pkg::MEGA_AW-1:0];
    flag_idx  = flag_we ? item_i.addr[tmr_pkg::MEGA_AW-1:0] : sel[tmr_pkg::MEGA_AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
      ok_q <= 1'b0;
    end else if (en_i) begin
      s3_q <= item_i;
      ok_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (mega_we) mega_mem[mega_idx] <= item_i.val[15:0];
      if (rd_en)   ment_rd_q <= mega_mem[mega_idx];
      if (flag_we) flag_mem[flag_idx] <= item_i.val[15:0];
      if (rd_en)   flag_rd_q <= flag_mem[flag_idx];
    end
  end

  assign item_o = s3_q;
  assign ment_o = ok_q ? ment_rd_q : 16'd0;
  assign walk_o = ok_q && tmr_pkg::is_walkable(flag_rd_q);

endmodule

// ===== rtl/tmr_colour_lookup.sv =====
module tmr_colour_lookup (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  tmr_pkg::pipe_t      item_i,
  input  logic [15:0]         ment_i,
  input  logic                walk_i,
  output tmr_pkg::pipe_t      item_o,
  output logic [23:0]         rgb_o,
  output logic                walk_o
);

  logic [7:0]  col_mem [tmr_pkg::COLOUR_DEPTH];
  logic [23:0] pal_mem [tmr_pkg::PAL_DEPTH];

  logic [7:0]      col_rd_q;
  logic [23:0]     pal_rd_q;
  tmr_pkg::pipe_t  s4_q, s5_q;
  logic            col_ok_q;
  logic            walk4_q, walk5_q;

  logic [14:0]                     mini;
  logic [2:0]                      col;
  logic [20:0]                     sel;
  logic                            mini_in;
  logic                            col_we, col_re;
  logic [tmr_pkg::COLOUR_AW-1:0]   col_idx;

  logic [7:0]                      colour;
  logic                            pal_we, pal_re;
  logic [tmr_pkg::PAL_AW-1:0]      pal_idx;

  // stage 3: colour byte read; flip bit mirrors the column (7-c is ~c)
  always_comb begin
    mini    = ment_i[15:1];
    col     = ment_i[0] ? ~item_i.px[2:0] : item_i.px[2:0];
    sel     = {mini, item_i.py[2:0], col};
    mini_in = 32'(mini) < tmr_pkg::MINITILES;
    col_we  = item_i.valid && (item_i.func == tmr_pkg::FUNC_COLOUR) &&
              (32'(item_i.addr) < tmr_pkg::COLOUR_DEPTH);
    col_re  = item_i.valid && (item_i.func == tmr_pkg::FUNC_RENDER) && mini_in;
    col_idx = col_we ? item_i.addr[tmr_pkg::COLOUR_AW-1:0] : sel[tmr_pkg::COLOUR_AW-1:0];
  end

  // stage 4: palette read
  always_comb begin
    colour  = col_ok_q ? col_rd_q : 8'd0;
    pal_we  = s4_q.valid && (s4_q.func == tmr_pkg::FUNC_PALETTE) &&
              (32'(s4_q.addr) < tmr_pkg::PAL_DEPTH);
    pal_re  = s4_q.valid && (s4_q.func == tmr_pkg::FUNC_RENDER);
    pal_idx = pal_we ? s4_q.addr[tmr_pkg::PAL_AW-1:0] : colour;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_q     <= '0;
      s5_q     <= '0;
      col_ok_q <= 1'b0;
    end else if (en_i) begin
      s4_q     <= item_i;
      s5_q     <= s4_q;
      col_ok_q <= col_re;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      walk4_q <= walk_i;
      walk5_q <= walk4_q;
      if (col_we) col_mem[col_idx] <= item_i.val[7:0];
      if (col_re) col_rd_q <= col_mem[col_idx];
      if (pal_we) pal_mem[pal_idx] <= s4_q.val;
      if (pal_re) pal_rd_q <= pal_mem[pal_idx];
    end
  end

  assign item_o = s5_q;
  assign rgb_o  = pal_rd_q;
  assign walk_o = walk5_q;

endmodule

// ===== rtl/tile_map_pixel_renderer_top.sv =====
// Channel   Dir  Payload
// in_i      in   func, table_address, write_value, pixel_x, pixel_y
// out_o     out  red, green, blue, walkable (one beat per render item)
//
// One item per cycle unless a stall holds the pipeline; a render beat leaves after the
// chain of five registered table reads (map, group, megatile/flag, colour, palette).
// Each table is written at the stage where it is read, so order is kept without forwarding.
// A result waiting in the output stage with out_o.ready low freezes the whole pipeline.
// Reset clears the pipeline item registers and read-valid flags; the tables hold garbage until written.
module tile_map_pixel_renderer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  tmr_in_if.sink      in_i,
  tmr_out_if.source   out_o
);

  tmr_pkg::pipe_t  in_item, tile_item, cell_item, colour_item;
  logic [15:0]     mega, ment;
  logic            cell_walk, fin_walk;
  logic [23:0]     rgb;
  logic            out_valid;
  logic            pipe_en;

  always_comb begin
    in_item.valid = in_i.valid;
    in_item.func  = in_i.func;
    in_item.addr  = in_i.table_address;
    in_item.val   = in_i.write_value;
    in_item.px    = in_i.pixel_x;
    in_item.py    = in_i.pixel_y;
  end

  assign out_valid = colour_item.valid && (colour_item.func == tmr_pkg::FUNC_RENDER);
  assign pipe_en   = !out_valid || out_o.ready;
  assign in_i.ready = pipe_en;

  tmr_tile_lookup u_tile (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .item_i (in_item),
    .item_o (tile_item),
    .mega_o (mega)
  );

  tmr_cell_lookup u_cell (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .item_i (tile_item),
    .mega_i (mega),
    .item_o (cell_item),
    .ment_o (ment),
    .walk_o (cell_walk)
  );

  tmr_colour_lookup u_colour (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .item_i (cell_item),
    .ment_i (ment),
    .walk_i (cell_walk),
    .item_o (colour_item),
    .rgb_o  (rgb),
    .walk_o (fin_walk)
  );

  assign out_o.valid    = out_valid;
  assign out_o.red      = rgb[23:16];
  assign out_o.green    = rgb[15:8];
  assign out_o.blue     = rgb[7:0];
  assign out_o.walkable = fin_walk;

`ifndef SYNTHESIS
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled without a pending output beat");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(tile_item) && $stable(cell_item) && $stable(colour_item))
    else $error("pipeline moved during a stall");

  a_item_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) ##1 pipe_en |=> tile_item.valid)
    else $error("accepted beat lost in tile stage");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam logic [2:0] FUNC_UNUSED = 3'd7;
  localparam int unsigned ADDR_SPAN = 1 << 21;
  localparam int PIPE_LAT = 5;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD = 300;
  localparam int PHASE_ITEMS = 155;

  typedef struct packed {
    logic [2:0]  func;
    logic [20:0] addr;
    logic [23:0] val;
    logic [11:0] px;
    logic [11:0] py;
  } tile_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       walkable;
  } pixel_t;

  logic      clk_i    = 1'b0;
  logic      rst_ni   = 1'b0;
  logic      tx_valid = 1'b0;
  tile_req_t tx_req   = '0;
  logic      rx_ready = 1'b0;

  tmr_in_if  in_if ();
  tmr_out_if out_if ();

  assign in_if.valid         = tx_valid;
  assign in_if.func          = tx_req.func;
  assign in_if.table_address = tx_req.addr;
  assign in_if.write_value   = tx_req.val;
  assign in_if.pixel_x       = tx_req.px;
  assign in_if.pixel_y       = tx_req.py;
  assign out_if.ready        = rx_ready;

  tile_map_pixel_renderer_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor copy of the tables, updated on accepted beats
  logic [15:0] map_mem    [int unsigned];
  logic [15:0] group_mem  [int unsigned];
  logic [15:0] mega_mem   [int unsigned];
  logic [7:0]  colour_mem [int unsigned];
  logic [15:0] flag_mem   [int unsigned];
  logic [23:0] pal_mem    [int unsigned];

  // generator's view of the tables, updated as items are queued
  logic [15:0] plan_map    [int unsigned];
  logic [15:0] plan_group  [int unsigned];
  logic [15:0] plan_mega   [int unsigned];
  logic [7:0]  plan_colour [int unsigned];
  logic [15:0] plan_flag   [int unsigned];
  logic [23:0] plan_pal    [int unsigned];

  tile_req_t req_q[$];
  pixel_t    pixel_q[$];

  int     tx_idle_pct  = 0;
  int     rx_stall_pct = 0;
  bit     hold_on      = 1'b0;
  int     hold_cnt     = 0;
  bit     in_fire      = 1'b0;
  int     mismatch_cnt = 0;
  int     pushed       = 0;
  pixel_t want_pix;

  function automatic bit chance(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic void push_req(input logic [2:0] func, input logic [20:0] addr,
                                   input logic [23:0] val, input logic [11:0] px,
                                   input logic [11:0] py);
    tile_req_t req;
    req.func = func;
    req.addr = addr;
    req.val  = val;
    req.px   = px;
    req.py   = py;
    req_q = {req_q, req};
    pushed++;
  endfunction

  function automatic void push_write(input logic [2:0] func, input logic [20:0] addr,
                                     input logic [23:0] val);
    case (func)
      tmr_pkg::FUNC_MAP:
        if (addr < tmr_pkg::MAP_DEPTH) plan_map[addr] = val[15:0];
      tmr_pkg::FUNC_GROUP:
        if (addr < tmr_pkg::GROUP_DEPTH) plan_group[addr] = val[15:0];
      tmr_pkg::FUNC_MEGA:
        if (addr < tmr_pkg::MEGA_DEPTH) plan_mega[addr] = val[15:0];
      tmr_pkg::FUNC_COLOUR:
        if (addr < tmr_pkg::COLOUR_DEPTH) plan_colour[addr] = val[7:0];
      tmr_pkg::FUNC_FLAG:
        if (addr < tmr_pkg::MEGA_DEPTH) plan_flag[addr] = val[15:0];
      tmr_pkg::FUNC_PALETTE:
        if (addr < tmr_pkg::PAL_DEPTH) plan_pal[addr] = val;
      default: ;
    endcase
    push_req(func, addr, val, 12'($urandom), 12'($urandom));
  endfunction

  function automatic logic [15:0] pick_map_word();
    int r = $urandom_range(0, 99);
    logic [11:0] grp;
    if (r < 75) begin
      grp = 12'($urandom_range(0, 15));
    end else if (r < 85) begin
      grp = chance(50) ? 12'(tmr_pkg::GROUPS - 1) :
                         12'($urandom_range(0, tmr_pkg::GROUPS - 1));
    end else begin
      grp = 12'($urandom_range(tmr_pkg::GROUPS, 4095));
    end
    return {grp, 4'($urandom)};
  endfunction

  function automatic logic [15:0] pick_mega();
    int r = $urandom_range(0, 99);
    if (r < 75) return 16'($urandom_range(0, 31));
    if (r < 85) return chance(50) ? 16'(tmr_pkg::MEGATILES - 1) :
                                    16'($urandom_range(0, tmr_pkg::MEGATILES - 1));
    return 16'($urandom_range(tmr_pkg::MEGATILES, 65535));
  endfunction

  function automatic logic [15:0] pick_ment();
    int r = $urandom_range(0, 99);
    if (r < 70) return {15'($urandom_range(0, 31)), 1'($urandom)};
    if (r < 90) return 16'($urandom);
    return 16'hFFFF;
  endfunction

  function automatic logic [15:0] pick_flag();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd2;
      3: return 16'd3;
      4: return 16'd16;
      5: return 16'd17;
      6: return 16'd18;
      7: return 16'd19;
      default: return 16'($urandom);
    endcase
  endfunction

  // Walk the lookup chain of one pixel, queue writes for every entry it will
  // read that is still unwritten (or, at random, rewrite it), then the render.
  function automatic void plan_render(input logic [11:0] px, input logic [11:0] py,
                                      input int rewrite_pct);
    int unsigned map_idx, mega_idx, col_idx;
    logic [15:0] word, mega, ment;
    logic [3:0]  quad;
    logic [2:0]  col;
    logic [7:0]  colour;
    map_idx = 32'({py[11:5], px[11:5]});
    quad    = {py[4:3], px[4:3]};
    col     = px[2:0];
    if (!plan_map.exists(map_idx) || chance(rewrite_pct))
      push_write(tmr_pkg::FUNC_MAP, 21'(map_idx), {8'($urandom), pick_map_word()});
    word = plan_map[map_idx];
    mega = '0;
    // group*16+index is the map word itself
    if (word[15:4] < tmr_pkg::GROUPS) begin
      if (!plan_group.exists(word) || chance(rewrite_pct))
        push_write(tmr_pkg::FUNC_GROUP, 21'(word), {8'($urandom), pick_mega()});
      mega = plan_group[word];
    end
    ment = '0;
    if (mega < tmr_pkg::MEGATILES) begin
      mega_idx = 32'({mega, quad});
      if (!plan_mega.exists(mega_idx) || chance(rewrite_pct))
        push_write(tmr_pkg::FUNC_MEGA, 21'(mega_idx), {8'($urandom), pick_ment()});
      if (!plan_flag.exists(mega_idx) || chance(rewrite_pct))
        push_write(tmr_pkg::FUNC_FLAG, 21'(mega_idx), {8'($urandom), pick_flag()});
      ment = plan_mega[mega_idx];
    end
    if (ment[0]) col = 3'd7 - col;
    col_idx = 32'({ment[15:1], py[2:0], col});
    if (!plan_colour.exists(col_idx) || chance(rewrite_pct))
      push_write(tmr_pkg::FUNC_COLOUR, 21'(col_idx), 24'($urandom));
    colour = plan_colour[col_idx];
    if (!plan_pal.exists(colour) || chance(rewrite_pct))
      push_write(tmr_pkg::FUNC_PALETTE, 21'(colour), 24'($urandom));
    push_req(tmr_pkg::FUNC_RENDER, 21'($urandom), 24'($urandom), px, py);
  endfunction

  function automatic void gen_random_step();
    int r = $urandom_range(0, 99);
    logic [2:0] wf;
    int unsigned depth;
    if (r < 80) begin
      if (chance(60)) plan_render(12'($urandom_range(0, 127)), 12'($urandom_range(0, 127)), 15);
      else plan_render(12'($urandom), 12'($urandom), 15);
    end else if (r < 95) begin
      wf = 3'($urandom_range(0, 5));
      case (wf)
        tmr_pkg::FUNC_MAP:     depth = tmr_pkg::MAP_DEPTH;
        tmr_pkg::FUNC_GROUP:   depth = tmr_pkg::GROUP_DEPTH;
        tmr_pkg::FUNC_COLOUR:  depth = tmr_pkg::COLOUR_DEPTH;
        tmr_pkg::FUNC_PALETTE: depth = tmr_pkg::PAL_DEPTH;
        default:               depth = tmr_pkg::MEGA_DEPTH;
      endcase
      // colour table spans the whole address field, so it has no stray writes
      if (r < 88 || depth == ADDR_SPAN)
        push_write(wf, 21'($urandom_range(0, depth - 1)), 24'($urandom));
      else
        push_write(wf, 21'($urandom_range(depth, ADDR_SPAN - 1)), 24'($urandom));
    end else begin
      push_req(FUNC_UNUSED, 21'($urandom), 24'($urandom), 12'($urandom), 12'($urandom));
    end
  endfunction

  function automatic pixel_t render_pixel(input logic [11:0] px, input logic [11:0] py);
    int unsigned map_idx, mega_idx, col_idx;
    logic [15:0] word, mega, ment, flag;
    logic [3:0]  quad;
    logic [2:0]  col;
    logic [7:0]  colour;
    logic [23:0] rgb;
    pixel_t      pix;
    map_idx = 32'({py[11:5], px[11:5]});
    quad    = {py[4:3], px[4:3]};
    col     = px[2:0];
    word = map_mem.exists(map_idx) ? map_mem[map_idx] : 16'h0;
    mega = '0;
    ment = '0;
    flag = '0;
    if (word[15:4] < tmr_pkg::GROUPS && group_mem.exists(word)) mega = group_mem[word];
    if (mega < tmr_pkg::MEGATILES) begin
      mega_idx = 32'({mega, quad});
      if (mega_mem.exists(mega_idx)) ment = mega_mem[mega_idx];
      if (flag_mem.exists(mega_idx)) flag = flag_mem[mega_idx];
    end
    if (ment[0]) col = 3'd7 - col;
    col_idx = 32'({ment[15:1], py[2:0], col});
    colour = colour_mem.exists(col_idx) ? colour_mem[col_idx] : 8'h0;
    rgb = pal_mem.exists(colour) ? pal_mem[colour] : 24'h0;
    pix.red      = rgb[23:16];
    pix.green    = rgb[15:8];
    pix.blue     = rgb[7:0];
    pix.walkable = (flag == 16'd1) || (flag == 16'd3) || (flag == 16'd17) || (flag == 16'd19);
    return pix;
  endfunction

  function automatic void apply_req(input tile_req_t req);
    case (req.func)
      tmr_pkg::FUNC_MAP:
        if (req.addr < tmr_pkg::MAP_DEPTH) map_mem[req.addr] = req.val[15:0];
      tmr_pkg::FUNC_GROUP:
        if (req.addr < tmr_pkg::GROUP_DEPTH) group_mem[req.addr] = req.val[15:0];
      tmr_pkg::FUNC_MEGA:
        if (req.addr < tmr_pkg::MEGA_DEPTH) mega_mem[req.addr] = req.val[15:0];
      tmr_pkg::FUNC_COLOUR:
        if (req.addr < tmr_pkg::COLOUR_DEPTH) colour_mem[req.addr] = req.val[7:0];
      tmr_pkg::FUNC_FLAG:
        if (req.addr < tmr_pkg::MEGA_DEPTH) flag_mem[req.addr] = req.val[15:0];
      tmr_pkg::FUNC_PALETTE:
        if (req.addr < tmr_pkg::PAL_DEPTH) pal_mem[req.addr] = req.val;
      tmr_pkg::FUNC_RENDER:
        pixel_q = {pixel_q, render_pixel(req.px, req.py)};
      default: ;
    endcase
  endfunction

  function automatic void load_directed();
    push_write(tmr_pkg::FUNC_PALETTE, 21'd0, 24'hFFFFFF);
    push_write(tmr_pkg::FUNC_PALETTE, 21'(tmr_pkg::PAL_DEPTH - 1), 24'h000000);
    // upper bits of a 16-bit entry are dropped: word 0 is group 0, index 0
    push_write(tmr_pkg::FUNC_MAP, 21'd0, 24'hFF0000);
    push_write(tmr_pkg::FUNC_GROUP, 21'd0, 24'h000000);
    push_write(tmr_pkg::FUNC_MEGA, 21'd0, 24'h000000);
    push_write(tmr_pkg::FUNC_FLAG, 21'd0, 24'h000013);
    push_write(tmr_pkg::FUNC_COLOUR, 21'd0, 24'hFFFF00);
    plan_render(12'd0, 12'd0, 0);
    // group past the table on the last tile
    push_write(tmr_pkg::FUNC_MAP, 21'(tmr_pkg::MAP_DEPTH - 1), 24'h00FFFF);
    plan_render(12'd4095, 12'd4095, 0);
    // last group, megatile past the table
    push_write(tmr_pkg::FUNC_MAP, 21'd1, 24'h007FFF);
    push_write(tmr_pkg::FUNC_GROUP, 21'(tmr_pkg::GROUP_DEPTH - 1), 24'h00FFFF);
    plan_render(12'd32, 12'd0, 0);
    // last megatile, last minitile with flip
    push_write(tmr_pkg::FUNC_MAP, 21'(tmr_pkg::MAP_TILES), 24'h000010);
    push_write(tmr_pkg::FUNC_GROUP, 21'd16, 24'(tmr_pkg::MEGATILES - 1));
    push_write(tmr_pkg::FUNC_MEGA, 21'((tmr_pkg::MEGATILES - 1) * 16), 24'h00FFFF);
    push_write(tmr_pkg::FUNC_FLAG, 21'((tmr_pkg::MEGATILES - 1) * 16), 24'h000001);
    push_write(tmr_pkg::FUNC_COLOUR, 21'(tmr_pkg::COLOUR_DEPTH - 64 + 7), 24'h0000FF);
    plan_render(12'd0, 12'd32, 0);
    // writes past the map, group, megatile, flag and palette tables are dropped
    push_write(tmr_pkg::FUNC_MAP, 21'(tmr_pkg::MAP_DEPTH), 24'hFFFFFF);
    push_write(tmr_pkg::FUNC_GROUP, 21'(tmr_pkg::GROUP_DEPTH), 24'hFFFFFF);
    push_write(tmr_pkg::FUNC_MEGA, 21'(tmr_pkg::MEGA_DEPTH), 24'hFFFFFF);
    push_write(tmr_pkg::FUNC_FLAG, 21'(tmr_pkg::MEGA_DEPTH), 24'hFFFFFF);
    push_write(tmr_pkg::FUNC_PALETTE, 21'(tmr_pkg::PAL_DEPTH), 24'hFFFFFF);
    push_write(tmr_pkg::FUNC_COLOUR, 21'(tmr_pkg::COLOUR_DEPTH - 1), 24'hA5A55A);
    push_req(FUNC_UNUSED, '1, '1, '1, '1);
    plan_render(12'd0, 12'd0, 0);
  endfunction

  task automatic wait_drained();
    while (req_q.size() != 0 || tx_valid || pixel_q.size() != 0) @(posedge clk_i);
  endtask

  // driver: hold a beat until taken, then maybe idle
  always @(negedge clk_i) begin
    if (rst_ni && (!tx_valid || in_fire)) begin
      if (req_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        tx_req   <= req_q.pop_front();
        tx_valid <= 1'b1;
      end else begin
        tx_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_on && hold_cnt < LONG_HOLD) begin
      rx_ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      rx_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // monitor: predict on input beats, check output beats
  always @(posedge clk_i) begin
    in_fire = rst_ni && in_if.valid && in_if.ready;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pixel_q.size() == 0) begin
        $error("pixel beat with none expected");
        mismatch_cnt++;
      end else begin
        want_pix = pixel_q.pop_front();
        if (out_if.red !== want_pix.red) begin
          $error("red: expected %0h, got %0h", want_pix.red, out_if.red);
          mismatch_cnt++;
        end
        if (out_if.green !== want_pix.green) begin
          $error("green: expected %0h, got %0h", want_pix.green, out_if.green);
          mismatch_cnt++;
        end
        if (out_if.blue !== want_pix.blue) begin
          $error("blue: expected %0h, got %0h", want_pix.blue, out_if.blue);
          mismatch_cnt++;
        end
        if (out_if.walkable !== want_pix.walkable) begin
          $error("walkable: expected %0b, got %0b", want_pix.walkable, out_if.walkable);
          mismatch_cnt++;
        end
      end
    end
    if (in_fire) apply_req({in_if.func, in_if.table_address, in_if.write_value,
                            in_if.pixel_x, in_if.pixel_y});
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int start;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    load_directed();
    wait_drained();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
          hold_on      = 1'b1;
        end
        1: begin
          tx_idle_pct  = 84;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 84;
        end
        default: begin
          tx_idle_pct  = 8;
          rx_stall_pct = 8;
        end
      endcase
      start = pushed;
      while (pushed - start < PHASE_ITEMS) gen_random_step();
      wait_drained();
    end
    repeat (4 * PIPE_LAT) @(posedge clk_i);
    if (mismatch_cnt == 0 && pixel_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tmr_pkg.sv
rtl/tmr_in_if.sv
rtl/tmr_out_if.sv
rtl/tmr_tile_lookup.sv
rtl/tmr_cell_lookup.sv
rtl/tmr_colour_lookup.sv
rtl/tile_map_pixel_renderer_top.sv
bench/tb.sv
